// ===== rtl/core/fpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants of the fixed-point to ASCII formatter.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int MAX_FIELD_WIDTH = 32;
    localparam int COL_W = $clog2(MAX_FIELD_WIDTH);

    localparam logic [2:0] REG_SCALE  = 3'd0;
    localparam logic [2:0] REG_RADIX  = 3'd1;
    localparam logic [2:0] REG_WIDTH  = 3'd2;
    localparam logic [2:0] REG_FRAC   = 3'd3;
    localparam logic [2:0] REG_FILL   = 3'd4;
    localparam logic [2:0] REG_SIGNED = 3'd5;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ALPHA = 8'h37;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_I,
        S_POW,
        S_MUL,
        S_DIV_F,
        S_SETUP,
        S_DIG_I,
        S_POINT,
        S_DIG_F,
        S_OUT
    } t_state;

    function automatic logic [7:0] digit_char(input logic [5:0] d);
        return (d < 6'd10) ? (CH_ZERO + {2'b0, d}) : (CH_ALPHA + {2'b0, d});
    endfunction

endpackage

// ===== rtl/core/fixed_point_to_ascii_formatter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_to_ascii_formatter
// Formats one fixed-point value as a fixed-width ASCII field.
// ----------------------------------------------------------------------------
// Usage: write registers over the cfg channel (i_cfg_valid/o_cfg_ready,
// index, data) while idle. Pulse i_start while o_busy is low with i_value.
// The block then emits field_width beats on o_out_char, one per o_strobe
// cycle, leftmost first, with o_last_char on the final beat.
// A shared restoring divider (one quotient bit per cycle) does every
// division: the integer split, then (after a multiply-by-radix loop that
// forms radix**frac_digits and a step that scales the remainder) the 64-bit
// fraction division, then one division per emitted digit; each pad column
// takes a single step, and the field_width output beats follow. Short
// values take far less, since digit loops stop dividing once the quotient
// reaches zero.
// Reset returns registers to defaults and the sequencer to idle. The
// receiver cannot stall; results are shown for exactly one cycle each.
// ----------------------------------------------------------------------------
module fixed_point_to_ascii_formatter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic signed [32:0] i_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_strobe,
    output logic [7:0]  o_out_char,
    output logic        o_last_char
);
    import fpa_pkg::*;

    logic [31:0] r_scale;
    logic [5:0]  r_radix, r_fwidth;
    logic [2:0]  r_frac;
    logic [7:0]  r_fill;
    logic        r_signed;

    t_state r_state, n_state;
    logic [7:0]  r_buf [MAX_FIELD_WIDTH];
    logic [63:0] r_dq;       // dividend / quotient shift register
    logic [32:0] r_drem;     // partial remainder
    logic [6:0]  r_cnt;
    logic [31:0] r_div;
    logic [31:0] r_ipart, r_fpart;
    logic [31:0] r_power;
    logic [5:0]  r_base, r_width, r_ilen;
    logic [2:0]  r_prec;
    logic        r_neg;
    logic [5:0]  r_col, r_left;
    logic        r_first;
    logic        r_dbusy;
    logic        r_strobe;
    logic [7:0]  r_char;
    logic        r_last;

    logic [32:0] w_trial;
    logic        w_ge;
    logic [63:0] w_mul;
    logic [31:0] w_mag;
    logic        w_vneg;
    logic [5:0]  w_base, w_width;
    logic [2:0]  w_prec;

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_busy      = (r_state != S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_out_char  = r_char;
    assign o_last_char = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= 32'd1;
            r_radix  <= 6'd10;
            r_fwidth <= 6'd8;
            r_frac   <= 3'd0;
            r_fill   <= 8'd32;
            r_signed <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_SCALE:  r_scale  <= i_cfg_data;
                REG_RADIX:  r_radix  <= i_cfg_data[5:0];
                REG_WIDTH:  r_fwidth <= i_cfg_data[5:0];
                REG_FRAC:   r_frac   <= i_cfg_data[2:0];
                REG_FILL:   r_fill   <= i_cfg_data[7:0];
                REG_SIGNED: r_signed <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_base  = (r_radix < 6'd2) ? 6'd2 : ((r_radix > 6'd36) ? 6'd36 : r_radix);
        w_width = (r_fwidth == 6'd0) ? 6'd1 :
                  ((r_fwidth > 6'(MAX_FIELD_WIDTH)) ? 6'(MAX_FIELD_WIDTH) : r_fwidth);
        w_prec  = (r_frac > 3'd6) ? 3'd6 : r_frac;
        if ({3'b0, w_width} < {6'b0, w_prec} + 9'd2)
            w_prec = (w_width >= 6'd2) ? 3'(w_width - 6'd2) : 3'd0;
        w_vneg = 1'b0;
        if (r_signed) begin
            if (i_value < -33'sd2147483648) w_mag = 32'h8000_0000;
            else if (i_value > 33'sd2147483647) w_mag = 32'h7FFF_FFFF;
            else if (i_value[32]) w_mag = 32'(-i_value);
            else w_mag = i_value[31:0];
            w_vneg = i_value[32];
        end else begin
            w_mag = i_value[32] ? 32'd0 : i_value[31:0];
        end
    end

    // shared divider step and multiplier
    assign w_trial = {r_drem[31:0], r_dq[63]} - {1'b0, r_div};
    assign w_ge    = ~w_trial[32] | r_drem[32];
    assign w_mul   = (r_state == S_POW) ? {32'b0, r_power} * {58'b0, r_base}
                                        : {32'b0, r_drem[31:0]} * {32'b0, r_power};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_start) n_state = S_DIV_I;
            S_DIV_I: if (r_cnt == 7'd63) n_state = S_POW;
            S_POW:   if (r_cnt[2:0] == r_prec) n_state = S_MUL;
            S_MUL:   n_state = S_DIV_F;
            S_DIV_F: if (r_cnt == 7'd63) n_state = S_SETUP;
            S_SETUP: n_state = S_DIG_I;
            S_DIG_I: if (r_left == 6'd0) n_state = (r_prec != 3'd0) ? S_POINT : S_OUT;
            S_POINT: n_state = S_DIG_F;
            S_DIG_F: if (r_left == 6'd0) n_state = S_OUT;
            S_OUT:   if (r_col + 6'd1 == r_width) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    // datapath of every state; in the digit loop, r_dbusy marks a division in progress
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
            r_dbusy  <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_base  <= w_base;
                        r_width <= w_width;
                        r_prec  <= w_prec;
                        r_ilen  <= (w_prec != 3'd0) ? w_width - {3'b0, w_prec} - 6'd1
                                                    : w_width;
                        r_neg   <= w_vneg;
                        r_div   <= (r_scale == 32'd0) ? 32'd1 : r_scale;
                        r_dq    <= {w_mag, 32'b0};
                        r_drem  <= '0;
                        r_cnt   <= 7'd32;
                    end
                end
                S_DIV_I, S_DIV_F: begin
                    r_drem <= w_ge ? w_trial : {r_drem[31:0], r_dq[63]};
                    r_dq   <= {r_dq[62:0], w_ge};
                    r_cnt  <= r_cnt + 7'd1;
                    if (r_cnt == 7'd63) begin
                        if (r_state == S_DIV_I) begin
                            r_ipart <= {r_dq[30:0], w_ge};
                            r_power <= 32'd1;
                            r_cnt   <= '0;
                        end else begin
                            r_fpart <= {r_dq[30:0], w_ge};
                        end
                    end
                end
                S_POW: begin
                    if (r_cnt[2:0] != r_prec) begin
                        r_power <= w_mul[31:0];
                        r_cnt   <= r_cnt + 7'd1;
                    end
                end
                S_MUL: begin
                    r_dq   <= w_mul;
                    r_drem <= '0;
                    r_cnt  <= '0;
                end
                S_SETUP: begin
                    r_dbusy <= 1'b0;
                    r_first <= 1'b1;
                    r_div   <= {26'b0, r_base};
                    if (r_neg && r_ipart != 32'd0) begin
                        r_buf[0] <= CH_MINUS;
                        r_left   <= (r_ilen > 6'd1) ? r_ilen - 6'd1 : 6'd0;
                    end else begin
                        r_left <= r_ilen;
                    end
                    r_col <= r_ilen - 6'd1;
                    r_dq  <= {r_ipart, 32'b0};
                end
                S_DIG_I, S_DIG_F: begin
                    if (r_left != 6'd0) begin
                        if (!r_dbusy) begin
                            if (r_first || r_dq[63:32] != 32'd0) begin
                                r_dbusy <= 1'b1;
                                r_drem  <= '0;
                                r_cnt   <= 7'd32;
                            end else begin
                                r_buf[r_col[COL_W-1:0]] <=
                                    (r_state == S_DIG_I) ? r_fill : CH_ZERO;
                                r_col  <= r_col - 6'd1;
                                r_left <= r_left - 6'd1;
                            end
                        end else begin
                            r_drem <= w_ge ? w_trial : {r_drem[31:0], r_dq[63]};
                            r_dq   <= {r_dq[62:0], w_ge};
                            r_cnt  <= r_cnt + 7'd1;
                            if (r_cnt == 7'd63) begin
                                r_dbusy <= 1'b0;
                                r_first <= 1'b0;
                                r_dq    <= {r_dq[30:0], w_ge, 32'b0};
                                r_buf[r_col[COL_W-1:0]] <= digit_char(
                                    w_ge ? w_trial[5:0] : {r_drem[4:0], r_dq[63]});
                                r_col  <= r_col - 6'd1;
                                r_left <= r_left - 6'd1;
                            end
                        end
                    end else begin
                        r_col <= '0;
                    end
                end
                S_POINT: begin
                    r_buf[r_ilen[COL_W-1:0]] <= CH_POINT;
                    r_col   <= r_width - 6'd1;
                    r_left  <= {3'b0, r_prec};
                    r_first <= 1'b1;
                    r_dbusy <= 1'b0;
                    r_dq    <= {r_fpart, 32'b0};
                end
                S_OUT: begin
                    r_strobe <= 1'b1;
                    r_char   <= r_buf[r_col[COL_W-1:0]];
                    r_last   <= (r_col + 6'd1 == r_width);
                    r_col    <= r_col + 6'd1;
                end
                default: ;
            endcase
        end
    end

endmodule
